### hw/rtl/whtmf_pkg.sv
`default_nettype none

package whtmf_pkg;

  localparam int MAX_WINDOWS_DEF = 16;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_CLICK  = 2'd2
  } func_t;

  // what every cell does on a clock edge
  typedef enum logic [1:0] {
    SH_HOLD,
    SH_APPEND,
    SH_ROT_FULL,
    SH_ROT_SUB
  } shift_op_t;

  typedef struct packed {
    shift_op_t op;
  } cell_ctrl_t;

  typedef struct packed {
    logic [11:0] left_x;
    logic [10:0] bottom_y;
    logic [11:0] right_x;
    logic [10:0] top_y;
  } geom_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] left_x;
    logic [10:0] bottom_y;
    logic [11:0] right_x;
    logic [10:0] top_y;
    logic [11:0] point_x;
    logic [10:0] point_y;
  } req_t;

  typedef struct packed {
    logic       selected;
    logic [4:0] window_number;
  } rsp_t;

endpackage

`default_nettype wire

### hw/rtl/window_hit_test_move_to_front.sv
// z-ordered window stack with click hit test and move-to-front
//
// request channel (req_valid / req_ready / req) carries one command:
//   clear  - empties the stack, no response
//   append - puts a rectangle on top, numbered from 1 in load order, no
//            response; dropped when the stack is full
//   click  - finds the topmost window holding the point (edges inclusive),
//            moves it to the top and returns one response
// response channel (rsp_valid / rsp_ready / rsp) gives selected and the
// window number, or zeros on a miss.
// the stack lives in a row of cells that rotate one position per cycle
// while a click is worked on; the hit test looks only at the bottom cell.
// a click takes one scan rotation plus, on a hit, one rearranging
// rotation, each over the occupied cells.
// one request is worked on at a time; req_ready is high only when idle.
// a finished response sits in an output register, so appends and clears
// go on while it waits; a second click result waits until rsp_ready
// frees the register.
// after reset the stack is empty and no response is pending.
`default_nettype none

module window_hit_test_move_to_front #(
  parameter int MAX_WINDOWS = whtmf_pkg::MAX_WINDOWS_DEF
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_ready,
  input  whtmf_pkg::req_t  req,
  output logic             rsp_valid,
  input  wire              rsp_ready,
  output whtmf_pkg::rsp_t  rsp
);

  localparam int CW = $clog2(MAX_WINDOWS + 1);
  localparam int IW = $clog2(MAX_WINDOWS);
  localparam logic [CW-1:0] FULL = CW'(MAX_WINDOWS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_MOVE = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t              state;
  logic [CW-1:0]       total;
  logic [IW-1:0]       step;
  logic [IW-1:0]       hit_pos;
  logic [CW-1:0]       hit_num;
  logic                found;
  logic [11:0]         pt_x;
  logic [10:0]         pt_y;
  whtmf_pkg::rsp_t     res;

  whtmf_pkg::cell_ctrl_t ctrl;
  whtmf_pkg::geom_t      bus_geom;
  logic [CW-1:0]         bus_num;
  whtmf_pkg::geom_t      cell_geom [MAX_WINDOWS];
  logic [CW-1:0]         cell_num  [MAX_WINDOWS];

  logic          req_fire;
  logic          last_step;
  logic          hit0;
  logic [CW+4:0] num_wide;

  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;

  // step reaches the topmost occupied cell
  assign last_step = ((CW'(step) + CW'(1)) == total);

  // containment test on the bottom cell only
  assign hit0 = (pt_x >= cell_geom[0].left_x) && (pt_x <= cell_geom[0].right_x) &&
                (pt_y >= cell_geom[0].bottom_y) && (pt_y <= cell_geom[0].top_y);

  assign num_wide = {5'd0, hit_num};

  // command to the cell row
  always_comb begin
    ctrl.op = whtmf_pkg::SH_HOLD;
    if (req_fire && (req.func == whtmf_pkg::FUNC_APPEND) && (total < FULL)) begin
      ctrl.op = whtmf_pkg::SH_APPEND;
    end else if (state == ST_SCAN) begin
      ctrl.op = whtmf_pkg::SH_ROT_FULL;
    end else if (state == ST_MOVE) begin
      // bring the hit to the bottom and past it to the top, then rotate the
      // rest back into place underneath it
      ctrl.op = (step <= hit_pos) ? whtmf_pkg::SH_ROT_FULL : whtmf_pkg::SH_ROT_SUB;
    end
  end

  // broadcast bus: request rectangle on append, bottom cell on rotation
  always_comb begin
    if (state == ST_IDLE) begin
      bus_geom.left_x   = req.left_x;
      bus_geom.bottom_y = req.bottom_y;
      bus_geom.right_x  = req.right_x;
      bus_geom.top_y    = req.top_y;
      bus_num           = total + CW'(1);
    end else begin
      bus_geom = cell_geom[0];
      bus_num  = cell_num[0];
    end
  end

  for (genvar i = 0; i < MAX_WINDOWS; i++) begin : g_cell
    if (i == MAX_WINDOWS - 1) begin : g_top
      whtmf_cell #(.MAX_WINDOWS(MAX_WINDOWS), .IDX(i)) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .total     (total),
        .next_geom (bus_geom),
        .next_num  (bus_num),
        .bus_geom  (bus_geom),
        .bus_num   (bus_num),
        .geom      (cell_geom[i]),
        .num       (cell_num[i])
      );
    end else begin : g_mid
      whtmf_cell #(.MAX_WINDOWS(MAX_WINDOWS), .IDX(i)) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .total     (total),
        .next_geom (cell_geom[i+1]),
        .next_num  (cell_num[i+1]),
        .bus_geom  (bus_geom),
        .bus_num   (bus_num),
        .geom      (cell_geom[i]),
        .num       (cell_num[i])
      );
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      total     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // the done state reloads the output register on its own
      if (rsp_valid && rsp_ready && (state != ST_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            if (req.func == whtmf_pkg::FUNC_CLEAR) begin
              total <= '0;
            end else if (req.func == whtmf_pkg::FUNC_APPEND) begin
              if (total < FULL) begin
                total <= total + CW'(1);
              end
            end else if (req.func == whtmf_pkg::FUNC_CLICK) begin
              pt_x  <= req.point_x;
              pt_y  <= req.point_y;
              found <= 1'b0;
              step  <= '0;
              if (total == '0) begin
                res   <= '0;
                state <= ST_DONE;
              end else begin
                state <= ST_SCAN;
              end
            end
          end
        end
        // bottom-up pass; the last hit seen is the topmost one
        ST_SCAN: begin
          if (hit0) begin
            found   <= 1'b1;
            hit_pos <= step;
            hit_num <= cell_num[0];
          end
          if (last_step) begin
            step <= '0;
            if (found || hit0) begin
              state <= ST_MOVE;
            end else begin
              res   <= '0;
              state <= ST_DONE;
            end
          end else begin
            step <= step + IW'(1);
          end
        end
        ST_MOVE: begin
          if (last_step) begin
            res.selected      <= 1'b1;
            res.window_number <= num_wide[4:0];
            state             <= ST_DONE;
          end else begin
            step <= step + IW'(1);
          end
        end
        ST_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/whtmf_cell.sv
`default_nettype none

module whtmf_cell #(
  parameter int MAX_WINDOWS = whtmf_pkg::MAX_WINDOWS_DEF,
  parameter int IDX         = 0,
  localparam int CW = $clog2(MAX_WINDOWS + 1)
) (
  input  wire                     clk,
  input  whtmf_pkg::cell_ctrl_t   ctrl,
  input  wire  [CW-1:0]           total,
  input  whtmf_pkg::geom_t        next_geom,
  input  wire  [CW-1:0]           next_num,
  input  whtmf_pkg::geom_t        bus_geom,
  input  wire  [CW-1:0]           bus_num,
  output whtmf_pkg::geom_t        geom,
  output logic [CW-1:0]           num
);

  localparam logic [CW-1:0] POS0 = CW'(IDX);
  localparam logic [CW:0]   POS1 = (CW + 1)'(IDX + 1);
  localparam logic [CW:0]   POS2 = (CW + 1)'(IDX + 2);

  logic [CW:0] total_ext;
  assign total_ext = {1'b0, total};

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      whtmf_pkg::SH_HOLD: begin
      end
      whtmf_pkg::SH_APPEND: begin
        if (total == POS0) begin
          geom <= bus_geom;
          num  <= bus_num;
        end
      end
      // whole occupied row rotates down, bottom entry wraps to the top
      whtmf_pkg::SH_ROT_FULL: begin
        if (POS1 < total_ext) begin
          geom <= next_geom;
          num  <= next_num;
        end else if (POS1 == total_ext) begin
          geom <= bus_geom;
          num  <= bus_num;
        end
      end
      // same, but the top entry stays put
      whtmf_pkg::SH_ROT_SUB: begin
        if (POS2 < total_ext) begin
          geom <= next_geom;
          num  <= next_num;
        end else if (POS2 == total_ext) begin
          geom <= bus_geom;
          num  <= bus_num;
        end
      end
    endcase
  end

endmodule

`default_nettype wire
